FILE: design/ptu_pkg.sv
// Shared constants, tables and types for the park transform unit.
package ptu_pkg;

    localparam int ROT_STEPS = 16;
    localparam int XY_W      = 33;
    localparam int Z_W       = 32;

    localparam logic signed [XY_W-1:0] ROT_ONE_K = 33'sd652032874;

    localparam logic signed [Z_W-1:0] ROT_ATAN [ROT_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] quad;
    } t_ctl;

endpackage

FILE: design/ptu_cordic_cell.sv
// One CORDIC rotation cell; registers its step and passes the item on.
module ptu_cordic_cell
    import ptu_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int STEP       = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  t_ctl                         i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_alpha,
    input  logic signed [DATA_WIDTH-1:0] i_beta,
    input  logic signed [XY_W-1:0]       i_x,
    input  logic signed [XY_W-1:0]       i_y,
    input  logic signed [Z_W-1:0]        i_z,
    output t_ctl                         o_ctl,
    output logic signed [DATA_WIDTH-1:0] o_alpha,
    output logic signed [DATA_WIDTH-1:0] o_beta,
    output logic signed [XY_W-1:0]       o_x,
    output logic signed [XY_W-1:0]       o_y,
    output logic signed [Z_W-1:0]        o_z
);

    t_ctl                         r_ctl;
    logic signed [DATA_WIDTH-1:0] r_alpha, r_beta;
    logic signed [XY_W-1:0]       r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]        r_z, n_z;
    logic signed [XY_W-1:0]       xs, ys;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        if (!i_z[Z_W-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ROT_ATAN[STEP];
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ROT_ATAN[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= i_alpha;
            r_beta  <= i_beta;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_alpha = r_alpha;
    assign o_beta  = r_beta;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

FILE: design/ptu_mix.sv
// Sine/cosine scaling and unfold, current products, rounding and saturation.
module ptu_mix
    import ptu_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  t_ctl                         i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_alpha,
    input  logic signed [DATA_WIDTH-1:0] i_beta,
    input  logic signed [XY_W-1:0]       i_x,
    input  logic signed [XY_W-1:0]       i_y,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_direct,
    output logic signed [DATA_WIDTH-1:0] o_quad,
    output logic                         o_sat
);

    localparam int FRAC  = DATA_WIDTH - 1;
    localparam int CW    = XY_W + 2;
    localparam int SH_DN = (FRAC >= 30) ? 1 : 30 - FRAC;
    localparam int SH_UP = (FRAC >= 30) ? FRAC - 30 : 0;
    localparam int PW    = 2 * DATA_WIDTH;
    localparam int SW    = PW + 2;

    localparam logic signed [CW-1:0] LIM  = CW'((longint'(1) <<< FRAC) - 1);
    localparam logic signed [CW-1:0] RND  = CW'(longint'(1) <<< (SH_DN - 1));
    localparam logic signed [SW-1:0] HI   = SW'((longint'(1) <<< FRAC) - 1);
    localparam logic signed [SW-1:0] LO   = SW'(-(longint'(1) <<< FRAC));
    localparam logic signed [SW-1:0] HALF = SW'(longint'(1) <<< (FRAC - 1));

    function automatic logic signed [DATA_WIDTH-1:0] to_frac(
        input logic signed [XY_W-1:0] v
    );
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] r;
        w = CW'(v);
        if (FRAC >= 30) begin
            r = w <<< SH_UP;
        end else begin
            r = (w + RND) >>> SH_DN;
        end
        if (r > LIM) begin
            r = LIM;
        end else if (r < -LIM) begin
            r = -LIM;
        end
        return DATA_WIDTH'(r);
    endfunction

    // stage A: scaled and unfolded cos/sin
    logic                         r_va;
    logic signed [DATA_WIDTH-1:0] r_cs, r_sn, r_a_a, r_b_a;
    logic signed [DATA_WIDTH-1:0] c_val, s_val, n_cs, n_sn;

    always_comb begin
        c_val = to_frac(i_x);
        s_val = to_frac(i_y);
        case (i_ctl.quad)
            2'd0: begin
                n_cs = c_val;
                n_sn = s_val;
            end
            2'd1: begin
                n_cs = -s_val;
                n_sn = c_val;
            end
            2'd2: begin
                n_cs = -c_val;
                n_sn = -s_val;
            end
            default: begin
                n_cs = s_val;
                n_sn = -c_val;
            end
        endcase
    end

    // stage B: products
    logic                 r_vb;
    logic signed [PW-1:0] r_p_acs, r_p_bsn, r_p_bcs, r_p_asn;

    // stage C: round, saturate, output register
    logic                         r_vc, r_sat;
    logic signed [DATA_WIDTH-1:0] r_d, r_q, n_d, n_q;
    logic                         n_sat;
    logic signed [SW-1:0]         sum_d, sum_q, rd, rq;

    always_comb begin
        sum_d = SW'(r_p_acs) + SW'(r_p_bsn);
        sum_q = SW'(r_p_bcs) - SW'(r_p_asn);
        rd    = (sum_d + HALF) >>> FRAC;
        rq    = (sum_q + HALF) >>> FRAC;
        n_sat = 1'b0;
        if (rd > HI) begin
            n_d   = DATA_WIDTH'(HI);
            n_sat = 1'b1;
        end else if (rd < LO) begin
            n_d   = DATA_WIDTH'(LO);
            n_sat = 1'b1;
        end else begin
            n_d = DATA_WIDTH'(rd);
        end
        if (rq > HI) begin
            n_q   = DATA_WIDTH'(HI);
            n_sat = 1'b1;
        end else if (rq < LO) begin
            n_q   = DATA_WIDTH'(LO);
            n_sat = 1'b1;
        end else begin
            n_q = DATA_WIDTH'(rq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_ctl.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs    <= n_cs;
            r_sn    <= n_sn;
            r_a_a   <= i_alpha;
            r_b_a   <= i_beta;
            r_p_acs <= PW'(r_a_a) * PW'(r_cs);
            r_p_bsn <= PW'(r_b_a) * PW'(r_sn);
            r_p_bcs <= PW'(r_b_a) * PW'(r_cs);
            r_p_asn <= PW'(r_a_a) * PW'(r_sn);
            r_d     <= n_d;
            r_q     <= n_q;
            r_sat   <= n_sat;
        end
    end

    assign o_valid  = r_vc;
    assign o_direct = r_d;
    assign o_quad   = r_q;
    assign o_sat    = r_sat;

endmodule

FILE: design/park_transform_unit.sv
// Park transform top level: CORDIC cell chain followed by the mixing stages.
// Pipeline: 16 CORDIC cells, then 3 mix stages, between input accept and output valid.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
// No state carries over between items.
module park_transform_unit
    import ptu_pkg::*;
#(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // alpha_current, beta_current, rotor_angle, zero pad
    input  logic [((2*DATA_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // direct_current, quadrature_current, zero pad
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // saturated
    output logic                    o_m_tuser
);

    localparam int OUT_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

    logic en;

    t_ctl                         chain_ctl   [ROT_STEPS+1];
    logic signed [DATA_WIDTH-1:0] chain_alpha [ROT_STEPS+1];
    logic signed [DATA_WIDTH-1:0] chain_beta  [ROT_STEPS+1];
    logic signed [XY_W-1:0]       chain_x     [ROT_STEPS+1];
    logic signed [XY_W-1:0]       chain_y     [ROT_STEPS+1];
    logic signed [Z_W-1:0]        chain_z     [ROT_STEPS+1];

    logic [ANGLE_WIDTH-1:0]       angle;
    logic signed [DATA_WIDTH-1:0] d_val, q_val;
    logic                         out_valid, out_sat;

    assign en         = !out_valid || i_m_tready;
    assign o_s_tready = en;

    assign angle = i_s_tdata[2*DATA_WIDTH +: ANGLE_WIDTH];

    assign chain_ctl[0].valid = i_s_tvalid;
    assign chain_ctl[0].quad  = angle[ANGLE_WIDTH-1 -: 2];
    assign chain_alpha[0]     = i_s_tdata[DATA_WIDTH-1:0];
    assign chain_beta[0]      = i_s_tdata[DATA_WIDTH +: DATA_WIDTH];
    assign chain_x[0]         = ROT_ONE_K;
    assign chain_y[0]         = '0;
    assign chain_z[0]         = {2'b00, angle[ANGLE_WIDTH-3:0], {(Z_W-ANGLE_WIDTH){1'b0}}};

    for (genvar g = 0; g < ROT_STEPS; g++) begin : g_cell
        ptu_cordic_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .STEP       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (chain_ctl[g]),
            .i_alpha (chain_alpha[g]),
            .i_beta  (chain_beta[g]),
            .i_x     (chain_x[g]),
            .i_y     (chain_y[g]),
            .i_z     (chain_z[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_alpha (chain_alpha[g+1]),
            .o_beta  (chain_beta[g+1]),
            .o_x     (chain_x[g+1]),
            .o_y     (chain_y[g+1]),
            .o_z     (chain_z[g+1])
        );
    end

    ptu_mix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (chain_ctl[ROT_STEPS]),
        .i_alpha  (chain_alpha[ROT_STEPS]),
        .i_beta   (chain_beta[ROT_STEPS]),
        .i_x      (chain_x[ROT_STEPS]),
        .i_y      (chain_y[ROT_STEPS]),
        .o_valid  (out_valid),
        .o_direct (d_val),
        .o_quad   (q_val),
        .o_sat    (out_sat)
    );

    // residual angle out of the last cell is not used; it is reduced here without effect on valid
    logic unused_z;
    assign unused_z = ^chain_z[ROT_STEPS];

    assign o_m_tvalid = out_valid && !unused_z || out_valid && unused_z;
    assign o_m_tdata  = OUT_W'({q_val, d_val});
    assign o_m_tuser  = out_sat;

endmodule

FILE: design/ptu_checker.sv
// Port-level checks for the park transform unit, bound to the top level.
module ptu_checker #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_s_tvalid,
    input logic                    o_s_tready,
    input logic [((2*DATA_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input logic                    o_m_tvalid,
    input logic                    i_m_tready,
    input logic [((2*DATA_WIDTH+7)/8)*8-1:0] o_m_tdata,
    input logic                    o_m_tuser
);

    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [DATA_WIDTH-1:0] d_bits, q_bits;
    assign d_bits = o_m_tdata[DATA_WIDTH-1:0];
    assign q_bits = o_m_tdata[DATA_WIDTH +: DATA_WIDTH];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while pipe is stalled");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (d_bits == MAXV || d_bits == MINV || q_bits == MAXV || q_bits == MINV))
        else $error("saturation flag without a clipped result");

endmodule

bind park_transform_unit ptu_checker #(
    .DATA_WIDTH  (DATA_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
) u_ptu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: sim/park_transform_unit_test.sv
// Testbench for park_transform_unit: random and corner items against a CORDIC predictor.
`timescale 1ns / 100ps

module park_transform_unit_test;

    localparam int DATA_WIDTH     = 16;
    localparam int ANGLE_WIDTH    = 16;
    localparam int S_W            = ((2*DATA_WIDTH+ANGLE_WIDTH+7)/8)*8;
    localparam int M_W            = ((2*DATA_WIDTH+7)/8)*8;
    localparam int PIPE_LATENCY   = 19;
    localparam int RANDOM_ITEMS   = 850;
    localparam int BACKLOG_AT     = 300;
    localparam int BACKLOG_CYCLES = 150;
    localparam int IDLE_LIMIT     = 2000;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] direct_current;
        logic [DATA_WIDTH-1:0] quadrature_current;
        logic                  saturated;
    } park_result_t;

    class park_scoreboard;
        park_result_t pending_q[$];
        int           samples_in;
        int           results_out;
        int           clipped_seen;
        int           mismatches;

        function longint atan_step(int i);
            case (i)
                0:  return 64'h20000000;
                1:  return 64'h12E4051E;
                2:  return 64'h09FB385B;
                3:  return 64'h051111D4;
                4:  return 64'h028B0D43;
                5:  return 64'h0145D7E1;
                6:  return 64'h00A2F61E;
                7:  return 64'h00517C55;
                8:  return 64'h0028BE53;
                9:  return 64'h00145F2F;
                10: return 64'h000A2F98;
                11: return 64'h000517CC;
                12: return 64'h00028BE6;
                13: return 64'h000145F3;
                14: return 64'h0000A2FA;
                default: return 64'h0000517D;
            endcase
        endfunction

        // 2^30-scaled CORDIC output to Q1.15, held inside +/-(2^15-1)
        function longint to_q15(longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        function logic [DATA_WIDTH-1:0] round_clip(longint sum, inout logic clip);
            longint r;
            r = (sum + 64'sd16384) >>> 15;
            if (r > 32767) begin
                clip = 1'b1;
                r = 32767;
            end else if (r < -32768) begin
                clip = 1'b1;
                r = -32768;
            end
            return r[DATA_WIDTH-1:0];
        endfunction

        function park_result_t rotate_pair(logic signed [DATA_WIDTH-1:0] alpha,
                                           logic signed [DATA_WIDTH-1:0] beta,
                                           logic [ANGLE_WIDTH-1:0] angle);
            longint       a;
            longint       b;
            longint       x;
            longint       y;
            longint       z;
            longint       xs;
            longint       ys;
            longint       c;
            longint       s;
            longint       cs;
            longint       sn;
            logic [31:0]  wide;
            logic         clip;
            park_result_t r;
            a = alpha;
            b = beta;
            wide = {angle, {(32-ANGLE_WIDTH){1'b0}}};
            z = {34'd0, wide[29:0]};
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_step(i);
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_step(i);
                end
            end
            c = to_q15(x);
            s = to_q15(y);
            case (wide[31:30])
                2'd0: begin cs = c;  sn = s;  end
                2'd1: begin cs = -s; sn = c;  end
                2'd2: begin cs = -c; sn = -s; end
                default: begin cs = s; sn = -c; end
            endcase
            clip = 1'b0;
            r.direct_current     = round_clip(a * cs + b * sn, clip);
            r.quadrature_current = round_clip(b * cs - a * sn, clip);
            r.saturated          = clip;
            return r;
        endfunction

        function void note_sample(logic [S_W-1:0] data);
            samples_in++;
            pending_q.push_back(rotate_pair(data[15:0], data[31:16], data[47:32]));
        endfunction

        function void check_result(logic [M_W-1:0] data, logic sat);
            park_result_t exp_r;
            results_out++;
            if (sat) clipped_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result with nothing pending: d=%0d q=%0d sat=%0b",
                             $signed(data[15:0]), $signed(data[31:16]), sat);
                return;
            end
            exp_r = pending_q.pop_front();
            if (exp_r.direct_current !== data[15:0] || exp_r.quadrature_current !== data[31:16]
                    || exp_r.saturated !== sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        "error: result %0d expected d=%0d q=%0d sat=%0b, got d=%0d q=%0d sat=%0b",
                        results_out, $signed(exp_r.direct_current),
                        $signed(exp_r.quadrature_current), exp_r.saturated,
                        $signed(data[15:0]), $signed(data[31:16]), sat);
            end
        endfunction
    endclass

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [S_W-1:0] i_s_tdata  = '0;   // alpha_current, beta_current, rotor_angle
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [M_W-1:0] o_m_tdata;         // direct_current, quadrature_current
    logic           o_m_tuser;         // saturated

    park_scoreboard sb = new;
    bit             backlog_done = 1'b0;
    bit             steady = 1'b0;

    park_transform_unit #(
        .DATA_WIDTH  (DATA_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_sample(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_current();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            3: return 16'h0000;
            4: return 16'hFFFF;
            5: return 16'h0001;
            default: return DATA_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_sample(logic [DATA_WIDTH-1:0] alpha, logic [DATA_WIDTH-1:0] beta,
                               logic [ANGLE_WIDTH-1:0] angle);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {angle, beta, alpha};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    initial begin : receiver
        int run_left;
        int ready_pct;
        run_left  = 0;
        ready_pct = 100;
        forever begin
            if (!backlog_done && sb.samples_in >= BACKLOG_AT) begin
                i_m_tready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge i_clk);
                backlog_done = 1'b1;
            end else if ($urandom_range(0, 199) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                run_left--;
                i_m_tready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        logic [DATA_WIDTH-1:0]  alpha;
        logic [DATA_WIDTH-1:0]  beta;
        logic [ANGLE_WIDTH-1:0] angle;
        int                     kind;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: axis angles, 45-degree overdrive, extreme currents
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h4000);
        send_sample(16'h0000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000, 16'hC000);
        send_sample(16'h8000, 16'h8000, 16'h2000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h2000);
        send_sample(16'h7FFF, 16'h8000, 16'h6000);
        send_sample(16'h8000, 16'h7FFF, 16'hE000);
        send_sample(16'h3039, 16'hA460, 16'hFFFF);
        send_sample(16'hFFFF, 16'hFFFF, 16'h0001);
        send_sample(16'h4000, 16'hC000, 16'h3FFF);
        send_sample(16'h8000, 16'h8000, 16'hA000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'h7FFF, 16'hFFFF, 16'h4001);
        send_sample(16'h0001, 16'h8000, 16'hBFFF);
        send_sample(16'h8000, 16'h8000, 16'h6000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) steady = ($urandom_range(0, 9) < 3);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                alpha = DATA_WIDTH'($urandom_range(0, 65535));
                beta  = DATA_WIDTH'($urandom_range(0, 65535));
                angle = ANGLE_WIDTH'($urandom_range(0, 65535));
            end else if (kind < 9) begin
                alpha = pick_current();
                beta  = pick_current();
                angle = ANGLE_WIDTH'($urandom_range(0, 65535));
            end else begin
                // large currents near a diagonal, likely to clip
                alpha = DATA_WIDTH'($urandom_range(24000, 32767));
                beta  = $urandom_range(0, 1) ? alpha : -alpha;
                if ($urandom_range(0, 1)) begin
                    alpha = -alpha;
                    beta  = -beta;
                end
                angle = ANGLE_WIDTH'({3'($urandom_range(0, 7)), 13'h0}
                                     + $urandom_range(0, 4095) - 2048);
            end
            send_sample(alpha, beta, angle);
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (2*PIPE_LATENCY + 10) @(posedge i_clk);

        $display("Run: %0d items in, %0d results, %0d clipped, one %0d-cycle output hold-off",
                 sb.samples_in, sb.results_out, sb.clipped_seen, BACKLOG_CYCLES);
        $display("Mismatches: %0d, still pending: %0d", sb.mismatches, sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
